FILE: rtl/rtvd_pkg.sv
// rtvd_pkg: shared widths, codes and constants for the rumble to vibration drive
// no dependencies; used by rtl/rumble_to_vibration_drive.sv
`default_nettype none

package rtvd_pkg;

	localparam int DEMAND_W   = 9;
	localparam int LEVEL_W    = 7;
	localparam int VIB_W      = 10;
	localparam int RUMBLE_W   = 8;
	localparam int TIME_W     = 32;
	localparam int INTERVAL_W = 16;
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 16;
	localparam int DIV_W      = 19;
	localparam int DIV_CNT_W  = 5;
	localparam int RECIP_W    = 19;
	localparam int RECIP_SH   = 19;

	typedef enum logic [1:0] {
		MODE_SETUP = 2'd0,
		MODE_LOOP  = 2'd1,
		MODE_ERROR = 2'd2,
		MODE_EXIT  = 2'd3
	} mode_t;

	localparam logic [CFG_IDX_W-1:0] CFG_RESET_INTERVAL = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_BIG_THRESHOLD  = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_PEAK_FLOOR     = 2'd2;

	localparam logic [INTERVAL_W-1:0] RESET_INTERVAL_RST = 16'd20000;
	localparam logic [DEMAND_W-1:0]   BIG_THRESHOLD_RST  = 9'd180;
	localparam logic [DEMAND_W-1:0]   PEAK_FLOOR_RST     = 9'd100;
	localparam logic [DEMAND_W-1:0]   DEMAND_PEAK_RST    = 9'd100;

	// floor(s * 7 / 10) == (s * 7 * 52429) >> 19 for any 8-bit s
	localparam logic [RECIP_W-1:0] SMALL_RECIP = 19'd367003;

	localparam logic [VIB_W-1:0]   VIB_BASE  = 10'd250;
	localparam logic [VIB_W-1:0]   VIB_SPAN  = 10'd750;
	localparam logic [VIB_W-1:0]   VIB_MAX   = 10'd1000;
	localparam logic [LEVEL_W-1:0] LEVEL_MAX = 7'd100;

	typedef enum logic [6:0] {
		ST_IDLE = 7'b0000001,
		ST_PREP = 7'b0000010,
		ST_PEAK = 7'b0000100,
		ST_DIV1 = 7'b0001000,
		ST_LVL  = 7'b0010000,
		ST_DIV2 = 7'b0100000,
		ST_DONE = 7'b1000000
	} state_t;

endpackage

`default_nettype wire

FILE: rtl/rumble_to_vibration_drive.sv
// rumble_to_vibration_drive: rumble demand to big-motor level and small-motor strength
// depends on rtl/rtvd_pkg.sv
//
// channel | signals                                           | handshake
// --------+---------------------------------------------------+-------------------
// in      | mode, big_rumble, small_rumble, time_ms           | in_valid / in_stall
// out     | big_enable, big_level_write, big_level,           | out_valid / out_stall
//         | vibrate_write, vibrate_strength                   |
// cfg     | cfg_index, cfg_data                               | cfg_valid / cfg_ready
//
// a loop word passes through PREP, PEAK, DIV1 when its demand is nonzero, LVL, DIV2 when
// needed, and DONE; setup, error and exit words go straight to DONE. the next word can be
// taken in the cycle after the result is loaded. loop words use the shared 19-step restoring
// divider, at most once for the strength and at most once for the big-motor target.
// arst_n clears the sequencer, its state and the config registers to their defaults.
// in_stall is high while a word is being worked; a held result in the output
// register does not block acceptance, only the final load waits on out_stall.
`default_nettype none

module rumble_to_vibration_drive (
	input  wire logic                                 clk,
	input  wire logic                                 arst_n,
	input  wire logic                                 in_valid,
	output logic                                      in_stall,
	input  wire logic [1:0]                           mode,
	input  wire logic [rtvd_pkg::RUMBLE_W-1:0]        big_rumble,
	input  wire logic [rtvd_pkg::RUMBLE_W-1:0]        small_rumble,
	input  wire logic [rtvd_pkg::TIME_W-1:0]          time_ms,
	output logic                                      out_valid,
	input  wire logic                                 out_stall,
	output logic                                      big_enable,
	output logic                                      big_level_write,
	output logic [rtvd_pkg::LEVEL_W-1:0]              big_level,
	output logic                                      vibrate_write,
	output logic [rtvd_pkg::VIB_W-1:0]                vibrate_strength,
	input  wire logic                                 cfg_valid,
	output logic                                      cfg_ready,
	input  wire logic [rtvd_pkg::CFG_IDX_W-1:0]       cfg_index,
	input  wire logic [rtvd_pkg::CFG_DATA_W-1:0]      cfg_data
);

	localparam int DW = rtvd_pkg::DEMAND_W;
	localparam int QW = rtvd_pkg::DIV_W;
	localparam int PW = rtvd_pkg::RUMBLE_W + rtvd_pkg::RECIP_W;

	rtvd_pkg::state_t                    state_q;
	rtvd_pkg::mode_t                     mode_q;
	logic [rtvd_pkg::RUMBLE_W-1:0]       big_q;
	logic [rtvd_pkg::RUMBLE_W-1:0]       small_q;
	logic [rtvd_pkg::TIME_W-1:0]         time_q;

	logic [rtvd_pkg::INTERVAL_W-1:0]     interval_q;
	logic [DW-1:0]                       thr_q;
	logic [DW-1:0]                       floor_q;

	logic [DW-1:0]                       peak_q;
	logic [rtvd_pkg::TIME_W-1:0]         last_q;
	logic [rtvd_pkg::LEVEL_W-1:0]        level_q;
	logic                                enable_q;

	logic [DW-1:0]                       demand_q;
	logic [rtvd_pkg::VIB_W-1:0]          vib_q;

	logic [DW-1:0]                       dv_rem_q;
	logic [QW-1:0]                       dv_quo_q;
	logic [DW-1:0]                       dv_den_q;
	logic [rtvd_pkg::DIV_CNT_W-1:0]      dv_cnt_q;

	logic                                out_valid_q;
	logic                                out_en_q;
	logic                                out_lvl_wr_q;
	logic [rtvd_pkg::LEVEL_W-1:0]        out_lvl_q;
	logic                                out_vib_wr_q;
	logic [rtvd_pkg::VIB_W-1:0]          out_vib_q;

	logic                                in_take;
	logic [PW-1:0]                       small_prod;
	logic [DW-1:0]                       demand_calc;
	logic [rtvd_pkg::TIME_W-1:0]         elapsed;
	logic [DW-1:0]                       peak_new;
	logic [QW-1:0]                       vib_dividend;
	logic [DW-1:0]                       lvl_diff;
	logic [QW-1:0]                       lvl_dividend;
	logic [DW:0]                         dv_trial;
	logic [DW:0]                         dv_diff;
	logic                                dv_ge;
	logic [DW-1:0]                       dv_rem_next;
	logic [QW-1:0]                       dv_quo_next;
	logic                                dv_last;
	logic                                out_free;

	assign in_stall  = (state_q != rtvd_pkg::ST_IDLE);
	assign in_take   = in_valid && !in_stall;
	assign cfg_ready = 1'b1;
	assign out_free  = !out_valid_q || !out_stall;

	// demand from the two rumble channels
	assign small_prod  = PW'(small_q) * PW'(rtvd_pkg::SMALL_RECIP);
	assign demand_calc = DW'(big_q) + DW'(small_prod[PW-1:rtvd_pkg::RECIP_SH]);
	assign elapsed     = time_q - last_q;

	assign peak_new     = (demand_q > peak_q) ? demand_q : peak_q;
	assign vib_dividend = QW'(demand_q) * QW'(rtvd_pkg::VIB_SPAN);
	assign lvl_diff     = demand_q - thr_q;
	assign lvl_dividend = QW'(lvl_diff) * QW'(rtvd_pkg::LEVEL_MAX);

	// shared restoring divider step
	assign dv_trial    = {dv_rem_q, dv_quo_q[QW-1]};
	assign dv_diff     = dv_trial - {1'b0, dv_den_q};
	assign dv_ge       = (dv_trial >= {1'b0, dv_den_q});
	assign dv_rem_next = dv_ge ? dv_diff[DW-1:0] : dv_trial[DW-1:0];
	assign dv_quo_next = {dv_quo_q[QW-2:0], dv_ge};
	assign dv_last     = (dv_cnt_q == '0);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			interval_q <= rtvd_pkg::RESET_INTERVAL_RST;
			thr_q      <= rtvd_pkg::BIG_THRESHOLD_RST;
			floor_q    <= rtvd_pkg::PEAK_FLOOR_RST;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				rtvd_pkg::CFG_RESET_INTERVAL: interval_q <= cfg_data;
				rtvd_pkg::CFG_BIG_THRESHOLD:  thr_q      <= cfg_data[DW-1:0];
				rtvd_pkg::CFG_PEAK_FLOOR:     floor_q    <= cfg_data[DW-1:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (in_take) begin
			mode_q  <= rtvd_pkg::mode_t'(mode);
			big_q   <= big_rumble;
			small_q <= small_rumble;
			time_q  <= time_ms;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= rtvd_pkg::ST_IDLE;
			peak_q   <= rtvd_pkg::DEMAND_PEAK_RST;
			last_q   <= '0;
			level_q  <= '0;
			enable_q <= 1'b0;
			demand_q <= '0;
			vib_q    <= '0;
			dv_rem_q <= '0;
			dv_quo_q <= '0;
			dv_den_q <= '0;
			dv_cnt_q <= '0;
		end else begin
			case (state_q)
				rtvd_pkg::ST_IDLE: begin
					if (in_take) begin
						case (rtvd_pkg::mode_t'(mode))
							rtvd_pkg::MODE_SETUP: begin
								enable_q <= 1'b1;
								state_q  <= rtvd_pkg::ST_DONE;
							end
							rtvd_pkg::MODE_EXIT: begin
								enable_q <= 1'b0;
								state_q  <= rtvd_pkg::ST_DONE;
							end
							rtvd_pkg::MODE_LOOP:  state_q <= rtvd_pkg::ST_PREP;
							default:              state_q <= rtvd_pkg::ST_DONE;
						endcase
					end
				end
				rtvd_pkg::ST_PREP: begin
					demand_q <= demand_calc;
					if (elapsed >= rtvd_pkg::TIME_W'(interval_q)) begin
						peak_q <= floor_q;
						last_q <= time_q;
					end
					state_q <= rtvd_pkg::ST_PEAK;
				end
				rtvd_pkg::ST_PEAK: begin
					peak_q <= peak_new;
					if (demand_q == '0) begin
						vib_q   <= '0;
						state_q <= rtvd_pkg::ST_LVL;
					end else begin
						dv_rem_q <= '0;
						dv_quo_q <= vib_dividend;
						dv_den_q <= peak_new;
						dv_cnt_q <= rtvd_pkg::DIV_CNT_W'(QW - 1);
						state_q  <= rtvd_pkg::ST_DIV1;
					end
				end
				rtvd_pkg::ST_DIV1: begin
					dv_rem_q <= dv_rem_next;
					dv_quo_q <= dv_quo_next;
					dv_cnt_q <= dv_cnt_q - 1'b1;
					if (dv_last) begin
						if (dv_quo_next > QW'(rtvd_pkg::VIB_SPAN))
							vib_q <= rtvd_pkg::VIB_MAX;
						else
							vib_q <= rtvd_pkg::VIB_BASE + dv_quo_next[rtvd_pkg::VIB_W-1:0];
						state_q <= rtvd_pkg::ST_LVL;
					end
				end
				rtvd_pkg::ST_LVL: begin
					if (demand_q > thr_q) begin
						if (peak_q > thr_q) begin
							dv_rem_q <= '0;
							dv_quo_q <= lvl_dividend;
							dv_den_q <= peak_q - thr_q;
							dv_cnt_q <= rtvd_pkg::DIV_CNT_W'(QW - 1);
							state_q  <= rtvd_pkg::ST_DIV2;
						end else begin
							if (level_q < rtvd_pkg::LEVEL_MAX)
								level_q <= level_q + 1'b1;
							state_q <= rtvd_pkg::ST_DONE;
						end
					end else begin
						if (level_q != '0)
							level_q <= level_q - 1'b1;
						state_q <= rtvd_pkg::ST_DONE;
					end
				end
				rtvd_pkg::ST_DIV2: begin
					dv_rem_q <= dv_rem_next;
					dv_quo_q <= dv_quo_next;
					dv_cnt_q <= dv_cnt_q - 1'b1;
					if (dv_last) begin
						// target is the quotient clipped to full scale
						if ((QW'(level_q) < dv_quo_next) && (level_q < rtvd_pkg::LEVEL_MAX))
							level_q <= level_q + 1'b1;
						state_q <= rtvd_pkg::ST_DONE;
					end
				end
				rtvd_pkg::ST_DONE: begin
					if (out_free)
						state_q <= rtvd_pkg::ST_IDLE;
				end
				default: state_q <= rtvd_pkg::ST_IDLE;
			endcase
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (state_q == rtvd_pkg::ST_DONE && out_free) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == rtvd_pkg::ST_DONE && out_free) begin
			out_en_q <= enable_q;
			case (mode_q)
				rtvd_pkg::MODE_LOOP: begin
					out_lvl_wr_q <= 1'b1;
					out_lvl_q    <= level_q;
					out_vib_wr_q <= 1'b1;
					out_vib_q    <= vib_q;
				end
				rtvd_pkg::MODE_ERROR: begin
					out_lvl_wr_q <= 1'b1;
					out_lvl_q    <= '0;
					out_vib_wr_q <= 1'b0;
					out_vib_q    <= '0;
				end
				default: begin
					out_lvl_wr_q <= 1'b0;
					out_lvl_q    <= '0;
					out_vib_wr_q <= 1'b0;
					out_vib_q    <= '0;
				end
			endcase
		end
	end

	assign out_valid        = out_valid_q;
	assign big_enable       = out_en_q;
	assign big_level_write  = out_lvl_wr_q;
	assign big_level        = out_lvl_q;
	assign vibrate_write    = out_vib_wr_q;
	assign vibrate_strength = out_vib_q;

	a_level_range: assert property (@(posedge clk) disable iff (!arst_n)
		level_q <= rtvd_pkg::LEVEL_MAX)
		else $error("big motor level above full scale");

	a_busy_after_take: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall |=> in_stall)
		else $error("word accepted while sequencer still idle");

	a_vib_word: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && vibrate_write |-> big_level_write && vibrate_strength <= rtvd_pkg::VIB_MAX)
		else $error("vibrate word inconsistent");

	a_div_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == rtvd_pkg::ST_DIV1 || state_q == rtvd_pkg::ST_DIV2 |-> dv_den_q != '0)
		else $error("divider running with zero divisor");

endmodule

`default_nettype wire

FILE: dv/tb_rumble_to_vibration_drive.sv
// tb_rumble_to_vibration_drive: self-checking bench for the rumble to vibration drive
// directed table then random phases under idling and stall, checked against typed expectations and a local predictor
// depends on rtl/rtvd_pkg.sv and rtl/rumble_to_vibration_drive.sv
`timescale 1ns / 100ps

module tb_rumble_to_vibration_drive;

	localparam int CYCLE_LIMIT   = 1000000;
	localparam int SETTLE_CYCLES = 48;
	localparam int PHASES        = 8;
	localparam int PHASE_WORDS   = 206;
	localparam int DIR_ROWS      = 29;
	localparam int SMALL_NUM     = 7;
	localparam int SMALL_DEN     = 10;

	typedef struct packed {
		rtvd_pkg::mode_t                md;
		logic [rtvd_pkg::RUMBLE_W-1:0]  big;
		logic [rtvd_pkg::RUMBLE_W-1:0]  sml;
		logic [rtvd_pkg::TIME_W-1:0]    tms;
	} drive_in_t;

	typedef struct packed {
		logic                         en;
		logic                         lw;
		logic [rtvd_pkg::LEVEL_W-1:0] lvl;
		logic                         vw;
		logic [rtvd_pkg::VIB_W-1:0]   vib;
	} drive_out_t;

	typedef enum logic {ROW_ITEM, ROW_CFG} row_kind_t;

	typedef struct {
		row_kind_t                         kind;
		logic [rtvd_pkg::CFG_IDX_W-1:0]    idx;
		logic [rtvd_pkg::CFG_DATA_W-1:0]   val;
		drive_in_t                         w;
		bit                                typed;
		drive_out_t                        e;
	} dir_row_t;

	localparam drive_in_t  NO_IN  = '0;
	localparam drive_out_t NO_OUT = '0;

	logic                             clk;
	logic                             arst_n;
	logic                             in_valid;
	logic                             in_stall;
	logic [1:0]                       mode;
	logic [rtvd_pkg::RUMBLE_W-1:0]    big_rumble;
	logic [rtvd_pkg::RUMBLE_W-1:0]    small_rumble;
	logic [rtvd_pkg::TIME_W-1:0]      time_ms;
	logic                             out_valid;
	logic                             out_stall;
	logic                             big_enable;
	logic                             big_level_write;
	logic [rtvd_pkg::LEVEL_W-1:0]     big_level;
	logic                             vibrate_write;
	logic [rtvd_pkg::VIB_W-1:0]       vibrate_strength;
	logic                             cfg_valid;
	logic                             cfg_ready;
	logic [rtvd_pkg::CFG_IDX_W-1:0]   cfg_index;
	logic [rtvd_pkg::CFG_DATA_W-1:0]  cfg_data;

	logic [rtvd_pkg::INTERVAL_W-1:0]  cfg_interval;
	logic [rtvd_pkg::DEMAND_W-1:0]    cfg_threshold;
	logic [rtvd_pkg::DEMAND_W-1:0]    cfg_floor;
	logic [rtvd_pkg::DEMAND_W-1:0]    pred_peak;
	logic [rtvd_pkg::TIME_W-1:0]      pred_last_reset;
	logic [rtvd_pkg::LEVEL_W-1:0]     pred_level;
	logic                             pred_enabled;

	drive_out_t                       expected_drive_q [$];
	drive_out_t                       want;
	logic [rtvd_pkg::TIME_W-1:0]      now_ms;
	int                               errors;
	int                               cycle_count;
	int                               send_idle_pct;
	int                               recv_stall_pct;
	int                               hold_cycles;

	dir_row_t dir_table [DIR_ROWS] = '{
		'{ROW_ITEM, rtvd_pkg::CFG_RESET_INTERVAL, 16'd0,
			'{rtvd_pkg::MODE_LOOP, 8'd0, 8'd0, 32'd0},
			1'b1, '{1'b0, 1'b1, 7'd0, 1'b1, 10'd0}},
		'{ROW_ITEM, rtvd_pkg::CFG_RESET_INTERVAL, 16'd0,
			'{rtvd_pkg::MODE_SETUP, 8'd0, 8'd0, 32'd1},
			1'b1, '{1'b1, 1'b0, 7'd0, 1'b0, 10'd0}},
		'{ROW_ITEM, rtvd_pkg::CFG_RESET_INTERVAL, 16'd0,
			'{rtvd_pkg::MODE_LOOP, 8'd255, 8'd255, 32'd5},
			1'b1, '{1'b1, 1'b1, 7'd1, 1'b1, 10'd1000}},
		'{ROW_ITEM, rtvd_pkg::CFG_RESET_INTERVAL, 16'd0,
			'{rtvd_pkg::MODE_LOOP, 8'd255, 8'd255, 32'd10},
			1'b1, '{1'b1, 1'b1, 7'd2, 1'b1, 10'd1000}},
		'{ROW_ITEM, rtvd_pkg::CFG_RESET_INTERVAL, 16'd0,
			'{rtvd_pkg::MODE_ERROR, 8'hAA, 8'h55, 32'd12},
			1'b1, '{1'b1, 1'b1, 7'd0, 1'b0, 10'd0}},
		'{ROW_ITEM, rtvd_pkg::CFG_RESET_INTERVAL, 16'd0,
			'{rtvd_pkg::MODE_LOOP, 8'd0, 8'd255, 32'd20},
			1'b0, NO_OUT},
		'{ROW_ITEM, rtvd_pkg::CFG_RESET_INTERVAL, 16'd0,
			'{rtvd_pkg::MODE_LOOP, 8'd181, 8'd0, 32'd30},
			1'b0, NO_OUT},
		'{ROW_ITEM, rtvd_pkg::CFG_RESET_INTERVAL, 16'd0,
			'{rtvd_pkg::MODE_LOOP, 8'd255, 8'd0, 32'd20030},
			1'b0, NO_OUT},
		'{ROW_ITEM, rtvd_pkg::CFG_RESET_INTERVAL, 16'd0,
			'{rtvd_pkg::MODE_LOOP, 8'd1, 8'd0, 32'd20031},
			1'b0, NO_OUT},
		'{ROW_ITEM, rtvd_pkg::CFG_RESET_INTERVAL, 16'd0,
			'{rtvd_pkg::MODE_LOOP, 8'd0, 8'd1, 32'd20032},
			1'b0, NO_OUT},
		'{ROW_ITEM, rtvd_pkg::CFG_RESET_INTERVAL, 16'd0,
			'{rtvd_pkg::MODE_LOOP, 8'd0, 8'd2, 32'd20033},
			1'b0, NO_OUT},
		'{ROW_ITEM, rtvd_pkg::CFG_RESET_INTERVAL, 16'd0,
			'{rtvd_pkg::MODE_EXIT, 8'hFF, 8'hFF, 32'd20034},
			1'b1, '{1'b0, 1'b0, 7'd0, 1'b0, 10'd0}},
		'{ROW_ITEM, rtvd_pkg::CFG_RESET_INTERVAL, 16'd0,
			'{rtvd_pkg::MODE_ERROR, 8'd0, 8'd0, 32'd0},
			1'b1, '{1'b0, 1'b1, 7'd0, 1'b0, 10'd0}},
		'{ROW_ITEM, rtvd_pkg::CFG_RESET_INTERVAL, 16'd0,
			'{rtvd_pkg::MODE_LOOP, 8'd100, 8'd100, 32'hFFFF_FFFF},
			1'b0, NO_OUT},
		'{ROW_ITEM, rtvd_pkg::CFG_RESET_INTERVAL, 16'd0,
			'{rtvd_pkg::MODE_LOOP, 8'd100, 8'd100, 32'h0000_0010},
			1'b0, NO_OUT},
		'{ROW_CFG, rtvd_pkg::CFG_RESET_INTERVAL, 16'd0, NO_IN, 1'b0, NO_OUT},
		'{ROW_CFG, rtvd_pkg::CFG_BIG_THRESHOLD, 16'd0, NO_IN, 1'b0, NO_OUT},
		'{ROW_CFG, rtvd_pkg::CFG_PEAK_FLOOR, 16'd0, NO_IN, 1'b0, NO_OUT},
		'{ROW_ITEM, rtvd_pkg::CFG_RESET_INTERVAL, 16'd0,
			'{rtvd_pkg::MODE_LOOP, 8'd0, 8'd0, 32'h5555_5555},
			1'b0, NO_OUT},
		'{ROW_ITEM, rtvd_pkg::CFG_RESET_INTERVAL, 16'd0,
			'{rtvd_pkg::MODE_LOOP, 8'd1, 8'd0, 32'hAAAA_AAAA},
			1'b0, NO_OUT},
		'{ROW_ITEM, rtvd_pkg::CFG_RESET_INTERVAL, 16'd0,
			'{rtvd_pkg::MODE_SETUP, 8'd0, 8'd0, 32'hAAAA_AAAB},
			1'b1, '{1'b1, 1'b0, 7'd0, 1'b0, 10'd0}},
		'{ROW_CFG, rtvd_pkg::CFG_RESET_INTERVAL, 16'hFFFF, NO_IN, 1'b0, NO_OUT},
		'{ROW_CFG, rtvd_pkg::CFG_BIG_THRESHOLD, 16'hFFFF, NO_IN, 1'b0, NO_OUT},
		'{ROW_CFG, rtvd_pkg::CFG_PEAK_FLOOR, 16'hFFFF, NO_IN, 1'b0, NO_OUT},
		'{ROW_ITEM, rtvd_pkg::CFG_RESET_INTERVAL, 16'd0,
			'{rtvd_pkg::MODE_LOOP, 8'd255, 8'd255, 32'h0000_1234},
			1'b0, NO_OUT},
		'{ROW_CFG, rtvd_pkg::CFG_BIG_THRESHOLD, 16'd432, NO_IN, 1'b0, NO_OUT},
		'{ROW_CFG, rtvd_pkg::CFG_PEAK_FLOOR, 16'd432, NO_IN, 1'b0, NO_OUT},
		'{ROW_ITEM, rtvd_pkg::CFG_RESET_INTERVAL, 16'd0,
			'{rtvd_pkg::MODE_LOOP, 8'd255, 8'd255, 32'h0000_1235},
			1'b0, NO_OUT},
		'{ROW_ITEM, rtvd_pkg::CFG_RESET_INTERVAL, 16'd0,
			'{rtvd_pkg::MODE_EXIT, 8'd0, 8'd0, 32'h0000_1236},
			1'b1, '{1'b0, 1'b0, 7'd0, 1'b0, 10'd0}}
	};

	rumble_to_vibration_drive u_top (
		.clk              (clk),
		.arst_n           (arst_n),
		.in_valid         (in_valid),
		.in_stall         (in_stall),
		.mode             (mode),
		.big_rumble       (big_rumble),
		.small_rumble     (small_rumble),
		.time_ms          (time_ms),
		.out_valid        (out_valid),
		.out_stall        (out_stall),
		.big_enable       (big_enable),
		.big_level_write  (big_level_write),
		.big_level        (big_level),
		.vibrate_write    (vibrate_write),
		.vibrate_strength (vibrate_strength),
		.cfg_valid        (cfg_valid),
		.cfg_ready        (cfg_ready),
		.cfg_index        (cfg_index),
		.cfg_data         (cfg_data)
	);

	function automatic drive_out_t predict_drive(drive_in_t w);
		drive_out_t                   r;
		logic [9:0]                   demand;
		logic [rtvd_pkg::TIME_W-1:0]  elapsed;
		int unsigned                  target;
		r = '0;
		case (w.md)
			rtvd_pkg::MODE_SETUP: pred_enabled = 1'b1;
			rtvd_pkg::MODE_LOOP: begin
				demand = 10'(w.big) + 10'((32'(w.sml) * SMALL_NUM) / SMALL_DEN);
				elapsed = w.tms - pred_last_reset;
				if (elapsed >= 32'(cfg_interval)) begin
					pred_peak = cfg_floor;
					pred_last_reset = w.tms;
				end
				if (demand > 10'(pred_peak))
					pred_peak = demand[rtvd_pkg::DEMAND_W-1:0];
				r.vw = 1'b1;
				if (demand == '0)
					r.vib = '0;
				else if (pred_peak == '0)
					r.vib = rtvd_pkg::VIB_MAX;
				else
					r.vib = rtvd_pkg::VIB_BASE + rtvd_pkg::VIB_W'(
						(32'(demand) * 32'(rtvd_pkg::VIB_SPAN)) / 32'(pred_peak));
				if (demand > 10'(cfg_threshold)) begin
					target = 32'(rtvd_pkg::LEVEL_MAX);
					if (pred_peak > cfg_threshold)
						target = ((32'(demand) - 32'(cfg_threshold)) *
							32'(rtvd_pkg::LEVEL_MAX)) /
							(32'(pred_peak) - 32'(cfg_threshold));
					if (target > 32'(rtvd_pkg::LEVEL_MAX))
						target = 32'(rtvd_pkg::LEVEL_MAX);
					if (32'(pred_level) < target)
						pred_level = pred_level + 1'b1;
				end else if (pred_level != '0) begin
					pred_level = pred_level - 1'b1;
				end
				r.lw = 1'b1;
				r.lvl = pred_level;
			end
			rtvd_pkg::MODE_ERROR: r.lw = 1'b1;
			default: pred_enabled = 1'b0;
		endcase
		r.en = pred_enabled;
		return r;
	endfunction

	function automatic logic [rtvd_pkg::RUMBLE_W-1:0] pick_rumble();
		case ($urandom_range(3))
			0: return rtvd_pkg::RUMBLE_W'($urandom);
			1: return rtvd_pkg::RUMBLE_W'($urandom_range(128, 255));
			2: return rtvd_pkg::RUMBLE_W'($urandom_range(0, 40));
			default: return $urandom_range(1) ? 8'hFF : 8'h00;
		endcase
	endfunction

	function automatic drive_in_t rand_word();
		drive_in_t    w;
		int unsigned  roll;
		roll = $urandom_range(99);
		if (roll < 76)
			w.md = rtvd_pkg::MODE_LOOP;
		else if (roll < 84)
			w.md = rtvd_pkg::MODE_SETUP;
		else if (roll < 92)
			w.md = rtvd_pkg::MODE_ERROR;
		else
			w.md = rtvd_pkg::MODE_EXIT;
		w.big = pick_rumble();
		w.sml = pick_rumble();
		// mostly steady time steps scaled to the interval, with rare jumps anywhere
		if ($urandom_range(99) < 3)
			now_ms = $urandom;
		else
			now_ms = now_ms + $urandom_range(0, 32'(cfg_interval) / 4 + 3);
		w.tms = now_ms;
		return w;
	endfunction

	task automatic check_field(input string name, input int unsigned exp_v,
		input int unsigned act_v);
		if (exp_v != act_v) begin
			$display("%0t %s mismatch: expected %0d, actual %0d", $time, name, exp_v, act_v);
			errors++;
		end
	endtask

	// called at a falling edge, returns at a falling edge
	task automatic send_word(input drive_in_t w, input bit typed, input drive_out_t typed_exp);
		drive_out_t pred;
		if (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
			in_valid = 1'b0;
			repeat ($urandom_range(1, 50)) @(negedge clk);
		end
		in_valid = 1'b1;
		mode = w.md;
		big_rumble = w.big;
		small_rumble = w.sml;
		time_ms = w.tms;
		do @(posedge clk); while (in_stall);
		pred = predict_drive(w);
		expected_drive_q.push_back(typed ? typed_exp : pred);
		@(negedge clk);
	endtask

	task automatic write_reg(input logic [rtvd_pkg::CFG_IDX_W-1:0] idx,
		input logic [rtvd_pkg::CFG_DATA_W-1:0] data);
		cfg_valid = 1'b1;
		cfg_index = idx;
		cfg_data = data;
		do @(posedge clk); while (!cfg_ready);
		case (idx)
			rtvd_pkg::CFG_RESET_INTERVAL: cfg_interval = data;
			rtvd_pkg::CFG_BIG_THRESHOLD:  cfg_threshold = data[rtvd_pkg::DEMAND_W-1:0];
			rtvd_pkg::CFG_PEAK_FLOOR:     cfg_floor = data[rtvd_pkg::DEMAND_W-1:0];
			default: ;
		endcase
		@(negedge clk);
		cfg_valid = 1'b0;
		@(negedge clk);
	endtask

	task automatic settle();
		in_valid = 1'b0;
		while (expected_drive_q.size() != 0) @(negedge clk);
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	initial begin
		out_stall = 1'b0;
		forever begin
			@(negedge clk);
			if (hold_cycles > 0) begin
				out_stall = 1'b1;
				hold_cycles--;
			end else begin
				out_stall = (recv_stall_pct != 0) && ($urandom_range(99) < recv_stall_pct);
			end
		end
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("** rumble_to_vibration_drive: FAILED **");
			$finish;
		end
	end

	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall) begin
			if (expected_drive_q.size() == 0) begin
				$display("%0t unexpected result word: level %0d strength %0d",
					$time, big_level, vibrate_strength);
				errors++;
			end else begin
				want = expected_drive_q.pop_front();
				check_field("big_enable", want.en, big_enable);
				check_field("big_level_write", want.lw, big_level_write);
				check_field("big_level", want.lvl, big_level);
				check_field("vibrate_write", want.vw, vibrate_write);
				check_field("vibrate_strength", want.vib, vibrate_strength);
			end
		end
	end

	initial begin
		logic [rtvd_pkg::CFG_DATA_W-1:0] iv;
		logic [rtvd_pkg::CFG_DATA_W-1:0] th;
		logic [rtvd_pkg::CFG_DATA_W-1:0] fl;
		arst_n = 1'b0;
		in_valid = 1'b0;
		mode = rtvd_pkg::MODE_SETUP;
		big_rumble = '0;
		small_rumble = '0;
		time_ms = '0;
		cfg_valid = 1'b0;
		cfg_index = rtvd_pkg::CFG_RESET_INTERVAL;
		cfg_data = '0;
		errors = 0;
		cycle_count = 0;
		send_idle_pct = 0;
		recv_stall_pct = 0;
		hold_cycles = 0;
		now_ms = 32'hFFFF_F000;
		cfg_interval = rtvd_pkg::RESET_INTERVAL_RST;
		cfg_threshold = rtvd_pkg::BIG_THRESHOLD_RST;
		cfg_floor = rtvd_pkg::PEAK_FLOOR_RST;
		pred_peak = rtvd_pkg::DEMAND_PEAK_RST;
		pred_last_reset = '0;
		pred_level = '0;
		pred_enabled = 1'b0;
		repeat (5) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		for (int i = 0; i < DIR_ROWS; i++) begin
			if (dir_table[i].kind == ROW_CFG) begin
				settle();
				write_reg(dir_table[i].idx, dir_table[i].val);
			end else begin
				send_word(dir_table[i].w, dir_table[i].typed, dir_table[i].e);
			end
		end

		for (int p = 0; p < PHASES; p++) begin
			settle();
			case (p)
				0: begin iv = rtvd_pkg::RESET_INTERVAL_RST; th = 16'd180; fl = 16'd100; end
				1: begin iv = 16'd1; th = 16'd0; fl = 16'd1; end
				2: begin iv = 16'd65535; th = 16'd432; fl = 16'd432; end
				3: begin iv = 16'd0; th = 16'd432; fl = 16'd1; end
				default: begin
					iv = 16'($urandom_range(1, 3000));
					th = {7'($urandom), 9'($urandom_range(0, 432))};
					fl = {7'($urandom), 9'($urandom_range(1, 432))};
				end
			endcase
			write_reg(rtvd_pkg::CFG_RESET_INTERVAL, iv);
			write_reg(rtvd_pkg::CFG_BIG_THRESHOLD, th);
			write_reg(rtvd_pkg::CFG_PEAK_FLOOR, fl);
			@(posedge clk);
			case (p % 4)
				0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
				1: begin send_idle_pct = 50; recv_stall_pct = 0;  end
				2: begin send_idle_pct = 0;  recv_stall_pct = 50; end
				default: begin send_idle_pct = 10; recv_stall_pct = 10; end
			endcase
			// long receiver hold while words keep coming, so the input backs up
			if (p == 4)
				hold_cycles = 400;
			@(negedge clk);
			for (int n = 0; n < PHASE_WORDS; n++)
				send_word(rand_word(), 1'b0, NO_OUT);
		end

		settle();
		if (errors == 0)
			$display("** rumble_to_vibration_drive: PASSED **");
		else
			$display("** rumble_to_vibration_drive: FAILED **");
		$finish;
	end

endmodule
